/* rtl/nws_pkg.sv */
// ----------------------------------------------------------------------------
// nws_pkg
// Shared types and constants for the nearest waypoint search block.
// ----------------------------------------------------------------------------
package nws_pkg;

   // Fixed port widths
   localparam int ENTRY_IDX_BITS = 6;
   localparam int POINT_BITS     = 24;
   localparam int COUNT_BITS     = 7;

   // Parameter defaults
   localparam int MAX_WAYPOINTS_DEF = 64;
   localparam int COORD_BITS_DEF    = 24;

   // Request action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Sideband that travels with each entry through the distance pipeline
   typedef struct packed {
      logic vld;
      logic last;
   } tag_type;

endpackage

/* rtl/nearest_waypoint_search.sv */
// ----------------------------------------------------------------------------
// nearest_waypoint_search
// Linear nearest-neighbor search over a table of planar waypoints.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is a valid/ready channel. action WRITE stores (point_x, point_y)
//   in slot entry_index and gives no response; slots at or
//   above MAX_WAYPOINTS are dropped. action QUERY scans entries
//   0 .. waypoint_count-1 and returns one rsp_* transfer carrying the index
//   of the entry with the smallest squared Euclidean distance (first one on
//   a tie) and found = 1. An empty table returns index 0, found = 0.
//   csr_wr_en/csr_wr_data load waypoint_count (clamped to MAX_WAYPOINTS at
//   query start); write it only while the block is idle.
//   A query scans the entries one after another; an empty table goes straight
//   to the result. The next request can be accepted once the block is idle
//   again. The single shared distance pipeline reads one RAM entry per cycle.
//   req_ready is low during a scan.
//   The result sits in an output register; the next request is accepted
//   while it waits for rsp_ready. A finished scan holds until that register
//   frees up. Reset clears the count, control state and rsp_valid; table
//   contents are undefined until written.
// ----------------------------------------------------------------------------
module nearest_waypoint_search #(
   parameter int MAX_WAYPOINTS = nws_pkg::MAX_WAYPOINTS_DEF,
   parameter int COORD_BITS    = nws_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic [nws_pkg::ENTRY_IDX_BITS-1:0]    req_entry_index,
   input  logic signed [nws_pkg::POINT_BITS-1:0] req_point_x,
   input  logic signed [nws_pkg::POINT_BITS-1:0] req_point_y,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [nws_pkg::ENTRY_IDX_BITS-1:0]    rsp_nearest_index,
   output logic                                  rsp_found,

   input  logic                                  csr_wr_en,
   input  logic [nws_pkg::COUNT_BITS-1:0]        csr_wr_data
);

   localparam int IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int CNT_W = ($clog2(MAX_WAYPOINTS + 1) > nws_pkg::COUNT_BITS) ?
                          $clog2(MAX_WAYPOINTS + 1) : nws_pkg::COUNT_BITS;
   localparam int D_W   = 2 * COORD_BITS + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [nws_pkg::COUNT_BITS-1:0] count_ff;
   logic [IDX_W-1:0]             addr_ff, addr_in;
   logic [IDX_W-1:0]             last_addr_ff, last_addr_in;
   logic                         have_ff, have_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic [D_W-1:0]               best_d_ff, best_d_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [nws_pkg::ENTRY_IDX_BITS-1:0] rsp_idx_ff, rsp_idx_in;
   logic                         rsp_found_ff, rsp_found_in;
   nws_pkg::tag_type             rd_tag_ff, rd_tag_in;
   logic [IDX_W-1:0]             rd_idx_ff;

   logic signed [COORD_BITS-1:0] qx_ff, qy_ff;

   logic                         accept;
   logic                         is_query;
   logic                         wr_en;
   logic                         issue;
   logic [CNT_W-1:0]             count_ext;
   logic [CNT_W-1:0]             n_clamp;
   logic [2*COORD_BITS-1:0]      wr_data;
   logic [2*COORD_BITS-1:0]      rd_data;
   logic signed [COORD_BITS-1:0] wx, wy;
   nws_pkg::tag_type             d_tag;
   logic [IDX_W-1:0]             d_idx;
   logic [D_W-1:0]               d_dist;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign is_query  = (req_action == nws_pkg::ACT_QUERY);

   // slot range check; out-of-range writes are dropped
   assign wr_en   = accept & ~is_query &
                    (CNT_W'(req_entry_index) < CNT_W'(MAX_WAYPOINTS));
   assign wr_data = {COORD_BITS'(req_point_y), COORD_BITS'(req_point_x)};

   assign count_ext = CNT_W'(count_ff);
   assign n_clamp   = (count_ext > CNT_W'(MAX_WAYPOINTS)) ?
                      CNT_W'(MAX_WAYPOINTS) : count_ext;

   assign issue = (state_ff == ST_SCAN);

   nws_ram #(
      .WIDTH(2 * COORD_BITS),
      .DEPTH(MAX_WAYPOINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_entry_index)),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign wx = rd_data[COORD_BITS-1:0];
   assign wy = rd_data[2*COORD_BITS-1:COORD_BITS];

   nws_dist #(
      .COORD_BITS(COORD_BITS),
      .IDX_W     (IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (rd_tag_ff),
      .in_idx   (rd_idx_ff),
      .qx       (qx_ff),
      .qy       (qy_ff),
      .wx       (wx),
      .wy       (wy),
      .out_tag  (d_tag),
      .out_idx  (d_idx),
      .out_dist (d_dist)
   );

   // sequencer and running minimum
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      last_addr_in = last_addr_ff;
      have_in      = have_ff;
      best_idx_in  = best_idx_ff;
      best_d_in    = best_d_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_found_in = rsp_found_ff;
      rd_tag_in.vld  = issue;
      rd_tag_in.last = (addr_ff == last_addr_ff);

      // strict less-than keeps the first minimum on a tie
      if (d_tag.vld && (!have_ff || (d_dist < best_d_ff))) begin
         have_in     = 1'b1;
         best_idx_in = d_idx;
         best_d_in   = d_dist;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               have_in      = 1'b0;
               best_idx_in  = '0;
               addr_in      = '0;
               last_addr_in = IDX_W'(n_clamp - CNT_W'(1));
               state_in     = (n_clamp == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + IDX_W'(1);
            if (addr_ff == last_addr_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (d_tag.vld && d_tag.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = nws_pkg::ENTRY_IDX_BITS'(best_idx_ff);
               rsp_found_in = have_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         addr_ff      <= '0;
         last_addr_ff <= '0;
         have_ff      <= 1'b0;
         best_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_idx_ff   <= '0;
         rsp_found_ff <= 1'b0;
         rd_tag_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         addr_ff      <= addr_in;
         last_addr_ff <= last_addr_in;
         have_ff      <= have_in;
         best_idx_ff  <= best_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_idx_ff   <= rsp_idx_in;
         rsp_found_ff <= rsp_found_in;
         rd_tag_ff    <= rd_tag_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      best_d_ff <= best_d_in;
      rd_idx_ff <= addr_ff;
      if (accept && is_query) begin
         qx_ff <= COORD_BITS'(req_point_x);
         qy_ff <= COORD_BITS'(req_point_y);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_idx_ff;
   assign rsp_found         = rsp_found_ff;

endmodule

/* rtl/nws_ram.sv */
// ----------------------------------------------------------------------------
// nws_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nws_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/nws_dist.sv */
// ----------------------------------------------------------------------------
// nws_dist
// Squared distance unit, three stages: abs difference, square, sum.
// Accepts one entry per cycle; tag and index ride along.
// ----------------------------------------------------------------------------
module nws_dist #(
   parameter int COORD_BITS = nws_pkg::COORD_BITS_DEF,
   parameter int IDX_W      = 6,
   localparam int D_W       = 2 * COORD_BITS + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nws_pkg::tag_type       in_tag,
   input  logic [IDX_W-1:0]       in_idx,
   input  logic signed [COORD_BITS-1:0] qx,
   input  logic signed [COORD_BITS-1:0] qy,
   input  logic signed [COORD_BITS-1:0] wx,
   input  logic signed [COORD_BITS-1:0] wy,
   output nws_pkg::tag_type       out_tag,
   output logic [IDX_W-1:0]       out_idx,
   output logic [D_W-1:0]         out_dist
);

   logic signed [COORD_BITS:0]  dx_s;
   logic signed [COORD_BITS:0]  dy_s;
   logic [COORD_BITS-1:0]       dx_in, dy_in;
   logic [COORD_BITS-1:0]       dx_ff, dy_ff;
   logic [2*COORD_BITS-1:0]     sqx_ff, sqy_ff;
   logic [D_W-1:0]              dist_ff;
   nws_pkg::tag_type            tag1_ff, tag2_ff, tag3_ff;
   logic [IDX_W-1:0]            idx1_ff, idx2_ff, idx3_ff;

   always_comb begin
      dx_s  = (COORD_BITS+1)'(qx) - (COORD_BITS+1)'(wx);
      dy_s  = (COORD_BITS+1)'(qy) - (COORD_BITS+1)'(wy);
      // |diff| < 2**COORD_BITS, fits unsigned in COORD_BITS
      dx_in = dx_s[COORD_BITS] ? COORD_BITS'(-dx_s) : COORD_BITS'(dx_s);
      dy_in = dy_s[COORD_BITS] ? COORD_BITS'(-dy_s) : COORD_BITS'(dy_s);
   end

   // tag valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      idx1_ff <= in_idx;
      sqx_ff  <= dx_ff * dx_ff;
      sqy_ff  <= dy_ff * dy_ff;
      idx2_ff <= idx1_ff;
      dist_ff <= D_W'(sqx_ff) + D_W'(sqy_ff);
      idx3_ff <= idx2_ff;
   end

   assign out_tag  = tag3_ff;
   assign out_idx  = idx3_ff;
   assign out_dist = dist_ff;

endmodule

/* tb/nearest_waypoint_search_tb.sv */
// ----------------------------------------------------------------------------
// nearest_waypoint_search_tb
// Self-checking bench for the nearest waypoint search block. A short table of
// hand-picked requests (empty table, coordinate extremes, ties) runs first.
// Random phases follow, each under its own waypoint count and handshake
// pressure. Every query response is checked against a scoreboard model of the
// waypoint table kept alongside the block.
// ----------------------------------------------------------------------------
module nearest_waypoint_search_tb;

   localparam int PT_W          = nws_pkg::POINT_BITS;
   localparam int IX_W          = nws_pkg::ENTRY_IDX_BITS;
   localparam int CN_W          = nws_pkg::COUNT_BITS;
   localparam int TABLE_DEPTH   = nws_pkg::MAX_WAYPOINTS_DEF;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 80;
   localparam int SETTLE_CYCLES = 8;   // allow slack for a trailing write to land
   localparam int ANSWER_DEPTH  = 256;

   localparam logic signed [PT_W-1:0] COORD_MAX = {1'b0, {(PT_W-1){1'b1}}};
   localparam logic signed [PT_W-1:0] COORD_MIN = {1'b1, {(PT_W-1){1'b0}}};

   // one query answer
   typedef struct packed {
      logic [IX_W-1:0] idx;
      logic            found;
   } nearest_type;

   // directed row: count to program, the request, and an answer where it is obvious
   typedef struct packed {
      logic [CN_W-1:0]        cnt;
      logic                   act;
      logic [IX_W-1:0]        slot;
      logic signed [PT_W-1:0] px;
      logic signed [PT_W-1:0] py;
      logic                   typed;
      logic [IX_W-1:0]        exp_idx;
      logic                   exp_found;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid       = 1'b0;
   logic                   req_ready;
   logic                   req_action      = nws_pkg::ACT_WRITE;
   logic [IX_W-1:0]        req_entry_index = '0;
   logic signed [PT_W-1:0] req_point_x     = '0;
   logic signed [PT_W-1:0] req_point_y     = '0;

   logic                   rsp_valid;
   logic                   rsp_ready       = 1'b0;
   logic [IX_W-1:0]        rsp_nearest_index;
   logic                   rsp_found;

   logic                   csr_wr_en       = 1'b0;
   logic [CN_W-1:0]        csr_wr_data     = '0;

   // scoreboard copy of the table and the count register
   logic signed [PT_W-1:0] wp_x [TABLE_DEPTH];
   logic signed [PT_W-1:0] wp_y [TABLE_DEPTH];
   bit                     wp_written [TABLE_DEPTH];
   logic [CN_W-1:0]        wp_count;

   // expected answers in query order; ring indexed by running counters
   nearest_type answer_fifo [ANSWER_DEPTH];
   int answer_wr = 0;
   int answer_rd = 0;

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int error_count     = 0;
   int cycle_count     = 0;
   int n_queries       = 0;
   int n_writes        = 0;
   int n_checked       = 0;
   int n_settings      = 0;

   // Directed requests. The count column is programmed (after a drain) when
   // it differs from the current setting.
   dir_row_type dir_rows [16] = '{
      // empty table: no entry compared, index 0, found clear
      '{7'd0, nws_pkg::ACT_QUERY, 6'd0,  24'sd0,    24'sd0,    1'b1, 6'd0, 1'b0},
      // empty table again; entry_index is a don't-care for a query
      '{7'd0, nws_pkg::ACT_QUERY, 6'd63, COORD_MAX, COORD_MIN, 1'b1, 6'd0, 1'b0},
      // corners, origin twice (tie), and a far slot
      '{7'd0, nws_pkg::ACT_WRITE, 6'd0,  COORD_MIN, COORD_MIN, 1'b0, 6'd0, 1'b0},
      '{7'd0, nws_pkg::ACT_WRITE, 6'd1,  COORD_MAX, COORD_MAX, 1'b0, 6'd0, 1'b0},
      '{7'd0, nws_pkg::ACT_WRITE, 6'd2,  24'sd0,    24'sd0,    1'b0, 6'd0, 1'b0},
      '{7'd0, nws_pkg::ACT_WRITE, 6'd3,  24'sd0,    24'sd0,    1'b0, 6'd0, 1'b0},
      '{7'd0, nws_pkg::ACT_WRITE, 6'd63, -24'sd1,   24'sd1,    1'b0, 6'd0, 1'b0},
      // exact hits on the corners
      '{7'd4, nws_pkg::ACT_QUERY, 6'd0,  COORD_MAX, COORD_MAX, 1'b1, 6'd1, 1'b1},
      '{7'd4, nws_pkg::ACT_QUERY, 6'd0,  COORD_MIN, COORD_MIN, 1'b1, 6'd0, 1'b1},
      // slots 2 and 3 hold the same point: first one wins
      '{7'd4, nws_pkg::ACT_QUERY, 6'd0,  24'sd0,    24'sd0,    1'b1, 6'd2, 1'b1},
      // widest differences the coordinates allow, then a query near the origin
      '{7'd4, nws_pkg::ACT_QUERY, 6'd0,  COORD_MAX, COORD_MIN, 1'b0, 6'd0, 1'b0},
      '{7'd4, nws_pkg::ACT_QUERY, 6'd42, -24'sd5,   24'sd7,    1'b0, 6'd0, 1'b0},
      // overwrite slot 3 so it stops tying with slot 2
      '{7'd4, nws_pkg::ACT_WRITE, 6'd3,  24'sd100,  -24'sd100, 1'b0, 6'd0, 1'b0},
      '{7'd4, nws_pkg::ACT_QUERY, 6'd0,  24'sd99,   -24'sd99,  1'b0, 6'd0, 1'b0},
      '{7'd4, nws_pkg::ACT_QUERY, 6'd0,  24'sd1,    24'sd1,    1'b0, 6'd0, 1'b0},
      // single entry: it is the answer wherever the query lands
      '{7'd1, nws_pkg::ACT_QUERY, 6'd0,  COORD_MAX, COORD_MAX, 1'b1, 6'd0, 1'b1}
   };

   // count settings of the random phases; 127 and 65 exercise the clamp
   int phase_counts [8] = '{1, 64, 127, 0, 7, 65, 2, 40};

   nearest_waypoint_search dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_entry_index   (req_entry_index),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_found         (rsp_found),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scan entries 0 .. count-1 (count clamped to the table depth) and keep the
   // first entry with the smallest squared distance. Squares fit in 49 bits.
   function automatic nearest_type nearest_of(input logic signed [PT_W-1:0] qx,
                                              input logic signed [PT_W-1:0] qy);
      nearest_type ans;
      longint      dx;
      longint      dy;
      longint      sq_dist;
      longint      best;
      int          n;
      ans  = '0;
      best = 0;
      n    = (wp_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(wp_count);
      for (int i = 0; i < n; i++) begin
         dx      = longint'(qx) - longint'(wp_x[i]);
         dy      = longint'(qy) - longint'(wp_y[i]);
         sq_dist = dx * dx + dy * dy;
         if (!ans.found || sq_dist < best) begin
            best      = sq_dist;
            ans.idx   = i[IX_W-1:0];
            ans.found = 1'b1;
         end
      end
      return ans;
   endfunction

   // lowest slot never written; queries must not scan at or beyond it
   function automatic int written_prefix();
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (!wp_written[i])
            return i;
      return TABLE_DEPTH;
   endfunction

   // mix of full-range, near-origin and extreme coordinates
   function automatic logic signed [PT_W-1:0] rand_coord();
      int pick;
      pick = int'($urandom_range(99));
      if (pick < 35)
         return PT_W'($urandom());
      else if (pick < 70)
         return PT_W'(int'($urandom_range(200)) - 100);
      else if (pick < 80)
         return COORD_MAX;
      else if (pick < 90)
         return COORD_MIN;
      else
         return $urandom_range(1) ? -24'sd1 : 24'sd0;
   endfunction

   // One request transfer. Valid stays high across back-to-back transfers and
   // only drops when the sender decides to idle or a drain begins.
   task automatic send_item(input logic act, input logic [IX_W-1:0] slot,
                            input logic signed [PT_W-1:0] px,
                            input logic signed [PT_W-1:0] py,
                            input logic typed, input nearest_type typed_ans);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_action      = act;
      req_entry_index = slot;
      req_point_x     = px;
      req_point_y     = py;
      do
         @(posedge clock);
      while (!req_ready);
      // transfer taken at this edge: apply it to the scoreboard in order
      if (act == nws_pkg::ACT_QUERY) begin
         answer_fifo[answer_wr % ANSWER_DEPTH] = typed ? typed_ans : nearest_of(px, py);
         answer_wr++;
         n_queries++;
      end else begin
         wp_x[slot]       = px;
         wp_y[slot]       = py;
         wp_written[slot] = 1'b1;
         n_writes++;
      end
   endtask

   // Wait until every query has answered and any trailing write has landed.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (answer_wr != answer_rd)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_count(input logic [CN_W-1:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      wp_count    = value;
      n_settings++;
   endtask

   task automatic set_pressure(input int mode);
      case (mode)
         0: begin
            sender_idle_pct = 0;
            rsp_stall_pct   = 0;
         end
         1: begin
            sender_idle_pct = 79;
            rsp_stall_pct   = 0;
         end
         2: begin
            sender_idle_pct = 0;
            rsp_stall_pct   = 79;
         end
         default: begin
            sender_idle_pct = 10;
            rsp_stall_pct   = 10;
         end
      endcase
   endtask

   // One random request. While the table holds fewer written entries than
   // the count scans, the next unwritten slot is filled first, so a query
   // never touches an entry that was never written.
   task automatic random_item();
      int          need;
      int          pre;
      int          src;
      nearest_type none;
      none = '0;
      need = (wp_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(wp_count);
      pre  = written_prefix();
      if (pre < need)
         send_item(nws_pkg::ACT_WRITE, pre[IX_W-1:0], rand_coord(), rand_coord(),
                   1'b0, none);
      else if ($urandom_range(99) < 25)
         send_item(nws_pkg::ACT_WRITE, IX_W'($urandom_range(TABLE_DEPTH - 1)),
                   rand_coord(), rand_coord(), 1'b0, none);
      else if (need > 0 && $urandom_range(9) < 2) begin
         // land exactly on a stored waypoint (or a duplicate of it)
         src = int'($urandom_range(need - 1));
         send_item(nws_pkg::ACT_QUERY, IX_W'($urandom()), wp_x[src], wp_y[src],
                   1'b0, none);
      end else
         send_item(nws_pkg::ACT_QUERY, IX_W'($urandom()), rand_coord(), rand_coord(),
                   1'b0, none);
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   // response checker: each transfer against the oldest pending answer
   always @(posedge clock) begin
      nearest_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answer_wr == answer_rd) begin
            $display("%0t: response with no query pending, index %0d found %0d",
                     $time, rsp_nearest_index, rsp_found);
            error_count++;
         end else begin
            want = answer_fifo[answer_rd % ANSWER_DEPTH];
            answer_rd++;
            n_checked++;
            if (rsp_nearest_index !== want.idx) begin
               $display("%0t: nearest_index mismatch, expected %0d actual %0d",
                        $time, want.idx, rsp_nearest_index);
               error_count++;
            end
            if (rsp_found !== want.found) begin
               $display("%0t: found mismatch, expected %0d actual %0d",
                        $time, want.found, rsp_found);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d answers still pending",
                  $time, answer_wr - answer_rd);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      nearest_type ans;
      wp_count = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         wp_x[i]       = '0;
         wp_y[i]       = '0;
         wp_written[i] = 1'b0;
      end
      set_pressure(0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, no idling
      foreach (dir_rows[r]) begin
         if (dir_rows[r].cnt != wp_count) begin
            drain();
            set_count(dir_rows[r].cnt);
         end
         ans.idx   = dir_rows[r].exp_idx;
         ans.found = dir_rows[r].exp_found;
         send_item(dir_rows[r].act, dir_rows[r].slot, dir_rows[r].px, dir_rows[r].py,
                   dir_rows[r].typed, ans);
      end

      // random phases, rotating through the pressure modes
      foreach (phase_counts[p]) begin
         drain();
         set_count(CN_W'(phase_counts[p]));
         set_pressure(p % 4);
         repeat (PHASE_ITEMS) random_item();
      end

      drain();
      $display("Sent %0d requests (%0d queries, %0d writes) over %0d count settings;",
               n_queries + n_writes, n_queries, n_writes, n_settings);
      $display("checked %0d responses under four handshake pressure modes.", n_checked);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
rtl/nws_pkg.sv
rtl/nws_ram.sv
rtl/nws_dist.sv
rtl/nearest_waypoint_search.sv
tb/nearest_waypoint_search_tb.sv
